/* sv/assert_macros.svh */
// assertion macros used by the rtl top level of the l2 learning forwarder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/l2mlf_pkg.sv */
// package with widths, types and helpers of the l2 learning forwarder
package l2mlf_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int MAX_PORTS     = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = IDX_W + 1;
	localparam int MAC_W         = 48;
	localparam int PORT_W        = 4;
	localparam int MASK_W        = 16;
	localparam int AP_W          = 5;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;

	localparam logic [AP_W-1:0] ACTIVE_PORTS_RST = AP_W'(4);

	typedef enum logic {
		REG_ACTIVE_PORTS = 1'b0,
		REG_NONE         = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
	} entry_t;

	function automatic logic [MASK_W-1:0] flood_mask(
		input logic [AP_W-1:0]   ap,
		input logic [PORT_W-1:0] port
	);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int p = 0; p < MASK_W; p++) begin
			if (p < MAX_PORTS && p < int'(ap) && p != int'(port))
				m[p] = 1'b1;
		end
		return m;
	endfunction

	function automatic logic [MASK_W-1:0] port_onehot(input logic [PORT_W-1:0] port);
		return MASK_W'(1) << port;
	endfunction

endpackage

/* sv/l2_mac_learning_forwarder.sv */
// top level of the l2 learning forwarder: mac table scan, learn and forward
//
// channel   signals                                     direction
// in        in_valid/in_ready, src_mac, dst_mac, in_port  transfer into block
// out       out_valid/out_ready, out_mask, dst_hit,       transfer out of block
//           learned_new, table_flushed
// cfg       psel/penable/pwrite/paddr/pwdata/prdata       apb register access
//
// a packet is handled by a scan that reads each table entry in turn, one read a cycle of the
// table ram, then by the write-back of its table entry, which also registers the result
// reset empties the table (count zero) and sets active_ports to 4; no clearing pass
// a result waits in the output register; the next packet is taken meanwhile,
// and only the write-back cycle waits while a result is still held
`include "assert_macros.svh"

module l2_mac_learning_forwarder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [l2mlf_pkg::MAC_W-1:0]       src_mac,
	input  logic [l2mlf_pkg::MAC_W-1:0]       dst_mac,
	input  logic [l2mlf_pkg::PORT_W-1:0]      in_port,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [l2mlf_pkg::MASK_W-1:0]      out_mask,
	output logic                              dst_hit,
	output logic                              learned_new,
	output logic                              table_flushed,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [l2mlf_pkg::PADDR_W-1:0]     paddr,
	input  logic [l2mlf_pkg::PDATA_W-1:0]     pwdata,
	output logic [l2mlf_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);
	import l2mlf_pkg::*;

	entry_t            mem [TABLE_ENTRIES];
	entry_t            rdata_s1;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  raddr_q;
	logic [AP_W-1:0]   active_ports_q;

	logic [MAC_W-1:0]  src_q, dst_q;
	logic [PORT_W-1:0] port_q;
	logic              src_hit_q, dst_hit_q;
	logic [IDX_W-1:0]  src_idx_q;
	logic [PORT_W-1:0] dst_port_q;

	logic              out_valid_q;
	logic [MASK_W-1:0] out_mask_q;
	logic              dst_hit_o_q, learned_q, flushed_q;

	logic              scan_issue, fin_go, flush;
	logic [IDX_W-1:0]  waddr;
	logic              cfg_wr;
	reg_idx_t          reg_idx;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_ACTIVE_PORTS);

	always_comb begin
		unique case (reg_idx)
			REG_ACTIVE_PORTS: prdata = PDATA_W'(active_ports_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_ports_q <= ACTIVE_PORTS_RST;
		end else if (cfg_wr) begin
			active_ports_q <= pwdata[AP_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SCAN;
			ST_SCAN:   if (raddr_q == cnt_q) state_d = ST_FINISH;
			ST_FINISH: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready   = 1'b0;
		scan_issue = 1'b0;
		fin_go     = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready   = 1'b1;
			ST_SCAN:   scan_issue = (raddr_q < cnt_q);
			ST_FINISH: fin_go     = !out_valid_q || out_ready;
			default:   in_ready   = 1'b0;
		endcase
	end

	assign flush = !src_hit_q && (cnt_q == CNT_W'(TABLE_ENTRIES));

	always_comb begin
		priority if (src_hit_q) waddr = src_idx_q;
		else if (flush)         waddr = '0;
		else                    waddr = cnt_q[IDX_W-1:0];
	end

	// table ram
	always_ff @(posedge clk) begin
		if (scan_issue)
			rdata_s1 <= mem[raddr_q[IDX_W-1:0]];
		if (fin_go)
			mem[waddr] <= '{mac: src_q, port: port_q};
	end

	always_ff @(posedge clk) begin
		if (scan_issue)
			rd_idx_s1 <= raddr_q[IDX_W-1:0];
		if (in_valid && in_ready) begin
			src_q  <= src_mac;
			dst_q  <= dst_mac;
			port_q <= in_port;
		end
		if (rd_vld_s1 && !src_hit_q && rdata_s1.mac == src_q)
			src_idx_q <= rd_idx_s1;
		if (rd_vld_s1 && !dst_hit_q && rdata_s1.mac == dst_q)
			dst_port_q <= rdata_s1.port;
		if (fin_go) begin
			learned_q <= !src_hit_q;
			flushed_q <= flush;
			priority if (dst_q == src_q) begin
				dst_hit_o_q <= 1'b1;
				out_mask_q  <= port_onehot(port_q);
			end else if (dst_hit_q && !flush) begin
				dst_hit_o_q <= 1'b1;
				out_mask_q  <= port_onehot(dst_port_q);
			end else begin
				dst_hit_o_q <= 1'b0;
				out_mask_q  <= flood_mask(active_ports_q, port_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			raddr_q     <= '0;
			rd_vld_s1   <= 1'b0;
			src_hit_q   <= 1'b0;
			dst_hit_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;
			if (in_valid && in_ready) begin
				raddr_q   <= '0;
				src_hit_q <= 1'b0;
				dst_hit_q <= 1'b0;
			end else begin
				if (scan_issue)
					raddr_q <= raddr_q + CNT_W'(1);
				if (rd_vld_s1 && rdata_s1.mac == src_q)
					src_hit_q <= 1'b1;
				if (rd_vld_s1 && rdata_s1.mac == dst_q)
					dst_hit_q <= 1'b1;
			end
			if (fin_go) begin
				priority if (src_hit_q) cnt_q <= cnt_q;
				else if (flush)         cnt_q <= CNT_W'(1);
				else                    cnt_q <= cnt_q + CNT_W'(1);
			end
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_mask      = out_mask_q;
	assign dst_hit       = dst_hit_o_q;
	assign learned_new   = learned_q;
	assign table_flushed = flushed_q;

	`ASSERT_NEXT(a_accept_starts_scan, clk, arst_n, in_valid && in_ready, state_q == ST_SCAN)
	`ASSERT_NOW(a_count_in_range, clk, arst_n, 1'b1, cnt_q <= CNT_W'(TABLE_ENTRIES))
	`ASSERT_NOW(a_read_below_count, clk, arst_n, rd_vld_s1, CNT_W'(rd_idx_s1) < cnt_q)
	`ASSERT_NEXT(a_finish_gives_result, clk, arst_n, fin_go, out_valid && in_ready)

endmodule
